// ===== rtl/bbpt_pkg.sv =====
package bbpt_pkg;

  localparam int MAX_BYTES = 262144;
  localparam int ADDR_W    = 18;
  localparam int CNT_W     = 19;
  localparam int HDR_LEN   = 24;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [1:0]  block_kind;
    logic [18:0] out_length;
  } out_item_t;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_FETCH  = 2'd2;
  localparam logic [1:0] CMD_SPARE  = 2'd3;

  localparam logic [2:0] ST_BYTE     = 3'd0;
  localparam logic [2:0] ST_ACCEPT   = 3'd1;
  localparam logic [2:0] ST_SHORT    = 3'd2;
  localparam logic [2:0] ST_NOFMT    = 3'd3;
  localparam logic [2:0] ST_BADHDR   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_8    = 2'd1;
  localparam logic [1:0] KIND_16   = 2'd2;

  localparam logic [2:0] CFG_DIRECTION = 3'd0;
  localparam logic [2:0] CFG_MIN_TOTAL = 3'd1;
  localparam logic [2:0] CFG_SCAN_WIN  = 3'd2;
  localparam logic [2:0] CFG_MIN_GUESS = 3'd3;
  localparam logic [2:0] CFG_MIN_BLK   = 3'd4;

  // Magic bytes 44 58 54 01 read as a little-endian word.
  localparam logic [31:0] MAGIC_WORD = 32'h0154_5844;
  localparam logic [31:0] MARK_DXT1  = 32'h4458_5431;
  localparam logic [31:0] MARK_DXT5  = 32'h4458_5435;

endpackage

// ===== rtl/bbpt_store.sv =====
module bbpt_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [bbpt_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic [bbpt_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                 rd_data_r
);

  logic [7:0] mem [bbpt_pkg::MAX_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

endmodule

// ===== rtl/block_byte_plane_transposer.sv =====
// Append, ignored commands and forward finish leave the block idle; a forward finish
// answers in the cycle after acceptance. A fetch passes through S_FETCH, where the
// registered store read returns. A reverse finish reads the 24 header bytes one per cycle
// from the store in S_HDR, checks them in S_CHK and then answers. The receiver cannot stall.
// Reset (synchronous, rst_n low) clears control state and loads register
// defaults; the byte store is not cleared and needs no clearing pass.
module block_byte_plane_transposer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bbpt_pkg::in_item_t  in_data,
  output logic                out_valid,
  output bbpt_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [18:0]         cfg_wdata
);

  localparam logic [1:0] PH_LOAD = 2'd0;
  localparam logic [1:0] PH_EMIT = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HDR   = 2'd1;
  localparam logic [1:0] S_CHK   = 2'd2;
  localparam logic [1:0] S_FETCH = 2'd3;

  localparam logic [4:0] HDR_LAST = 5'(bbpt_pkg::HDR_LEN);

  logic        dir_r;
  logic [18:0] min_total_r, scan_win_r, min_guess_r;
  logic [15:0] min_blk_r;

  logic [18:0] load_cnt_r;
  logic [1:0]  phase_r;
  logic [23:0] recent_r;
  logic        mark8_r, mark16_r;
  logic [31:0] hdr_type_r;
  logic [63:0] hdr_blk_r, hdr_len_r;
  logic        mode16_r;
  logic [18:0] blk_total_r, emit_idx_r, blk_idx_r;
  logic [3:0]  plane_idx_r;

  logic [1:0]   state_r;
  logic [4:0]   hdr_cnt_r;
  logic [191:0] hdr_buf_r;
  logic         f_hdr_r, f_oor_r, f_last_r;
  logic [7:0]   f_hdr_byte_r;

  logic                out_valid_r;
  bbpt_pkg::out_item_t out_data_r;

  logic [7:0] rd_data;

  function automatic bbpt_pkg::out_item_t mk_out(input logic [2:0] st, input logic [7:0] b,
                                                 input logic last, input logic [1:0] kind,
                                                 input logic [18:0] len);
    bbpt_pkg::out_item_t o;
    o.status     = st;
    o.out_byte   = b;
    o.out_last   = last;
    o.block_kind = kind;
    o.out_length = len;
    return o;
  endfunction

  logic accept;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Append path.
  logic        app_restart, app_full, app_scan, app_wr;
  logic [18:0] app_cnt;
  logic [23:0] app_recent;
  logic [31:0] app_word;
  logic        app_mark8, app_mark16;

  assign app_restart = (phase_r != PH_LOAD);
  assign app_cnt     = app_restart ? '0 : load_cnt_r;
  assign app_recent  = app_restart ? '0 : recent_r;
  assign app_full    = (app_cnt >= 19'(bbpt_pkg::MAX_BYTES));
  assign app_word    = {app_recent, in_data.data_byte};
  assign app_scan    = (app_cnt >= 19'd3) && (app_cnt < scan_win_r);
  assign app_wr      = accept && (in_data.cmd == bbpt_pkg::CMD_APPEND) && !app_full;
  assign app_mark8   = (app_restart ? 1'b0 : mark8_r) |
                       (!app_full && app_scan && (app_word == bbpt_pkg::MARK_DXT1));
  assign app_mark16  = (app_restart ? 1'b0 : mark16_r) |
                       (!app_full && app_scan && (app_word == bbpt_pkg::MARK_DXT5));

  // Forward finish decision.
  logic        fw_short, fw_guess, fw_fmt_ok, fw_m16, fw_few;
  logic [18:0] fw_blocks;
  logic [19:0] fw_total;

  assign fw_short = (load_cnt_r < min_total_r);
  assign fw_guess = (load_cnt_r >= min_guess_r);

  always_comb begin
    fw_fmt_ok = 1'b1;
    fw_m16    = 1'b0;
    if (mark8_r) begin
      fw_m16 = 1'b0;
    end else if (mark16_r) begin
      fw_m16 = 1'b1;
    end else if ((load_cnt_r[3:0] == 4'd0) && fw_guess) begin
      fw_m16 = 1'b1;
    end else if ((load_cnt_r[2:0] == 3'd0) && fw_guess) begin
      fw_m16 = 1'b0;
    end else begin
      fw_fmt_ok = 1'b0;
    end
  end

  assign fw_blocks = fw_m16 ? (load_cnt_r >> 4) : (load_cnt_r >> 3);
  assign fw_few    = (fw_blocks < {3'b0, min_blk_r});
  assign fw_total  = {1'b0, load_cnt_r} + 20'(bbpt_pkg::HDR_LEN);

  // Reverse header check, on the gathered header bytes.
  logic        rv_magic_ok, rv_t1, rv_t5, rv_len_bad, rv_blk_bad;
  logic [31:0] rv_type;
  logic [63:0] rv_blk, rv_len, rv_cap;
  logic [18:0] rv_payload;

  assign rv_magic_ok = (hdr_buf_r[31:0] == bbpt_pkg::MAGIC_WORD);
  assign rv_type     = hdr_buf_r[63:32];
  assign rv_blk      = hdr_buf_r[127:64];
  assign rv_len      = hdr_buf_r[191:128];
  assign rv_t1       = (rv_type == 32'd1);
  assign rv_t5       = (rv_type == 32'd5);
  assign rv_payload  = load_cnt_r - 19'(bbpt_pkg::HDR_LEN);
  assign rv_len_bad  = (rv_len > {45'b0, rv_payload});
  assign rv_cap      = rv_t5 ? (rv_len >> 4) : (rv_len >> 3);
  assign rv_blk_bad  = (rv_blk > rv_cap);

  // Fetch address generation.
  logic [18:0]  k_off;
  logic [19:0]  k1, bi1;
  logic [22:0]  planes, fw_paddr, rv_prod;
  logic [23:0]  f_addr;
  logic         k_hdr, fw_in_planes, rv_in_planes, f_last, f_oor;
  logic [4:0]   pl1;
  logic [18:0]  blk_nxt;
  logic [3:0]   plane_nxt;
  logic [191:0] hdr_vec;
  logic [7:0]   hdr_byte;

  assign k1      = {1'b0, emit_idx_r} + 20'd1;
  assign k_hdr   = (emit_idx_r < 19'(bbpt_pkg::HDR_LEN));
  assign k_off   = emit_idx_r - 19'(bbpt_pkg::HDR_LEN);
  assign planes  = mode16_r ? {blk_total_r, 4'b0} : {1'b0, blk_total_r, 3'b0};
  assign fw_in_planes = ({4'b0, k_off} < planes);
  assign rv_in_planes = ({4'b0, emit_idx_r} < planes);
  assign fw_paddr = (mode16_r ? {blk_idx_r, 4'b0} : {1'b0, blk_idx_r, 3'b0}) +
                    {19'b0, plane_idx_r};
  assign rv_prod  = 23'(plane_idx_r * blk_total_r);
  assign bi1      = {1'b0, blk_idx_r} + 20'd1;
  assign pl1      = {1'b0, plane_idx_r} + 5'd1;
  assign hdr_vec  = {hdr_len_r, hdr_blk_r, hdr_type_r, bbpt_pkg::MAGIC_WORD};
  assign hdr_byte = hdr_vec[emit_idx_r[4:0]*8 +: 8];

  always_comb begin
    f_addr    = '0;
    blk_nxt   = blk_idx_r;
    plane_nxt = plane_idx_r;
    if (!dir_r) begin
      if (fw_in_planes) begin
        f_addr = {1'b0, fw_paddr};
        if (bi1 >= {1'b0, blk_total_r}) begin
          blk_nxt   = '0;
          plane_nxt = plane_idx_r + 4'd1;
        end else begin
          blk_nxt = bi1[18:0];
        end
      end else begin
        f_addr = {5'b0, k_off};
      end
    end else begin
      if (rv_in_planes) begin
        f_addr = {1'b0, rv_prod} + {5'b0, blk_idx_r} + 24'(bbpt_pkg::HDR_LEN);
        if (pl1 >= (mode16_r ? 5'd16 : 5'd8)) begin
          plane_nxt = '0;
          blk_nxt   = bi1[18:0];
        end else begin
          plane_nxt = pl1[3:0];
        end
      end else begin
        f_addr = {5'b0, emit_idx_r} + 24'(bbpt_pkg::HDR_LEN);
      end
    end
  end

  // Header bytes in the forward direction come from registers, not the store.
  logic f_from_hdr;
  assign f_from_hdr = !dir_r && k_hdr;
  assign f_oor      = (f_addr[23:bbpt_pkg::ADDR_W] != '0);
  assign f_last     = dir_r ? ((hdr_len_r[63:20] == '0) && (k1 >= hdr_len_r[19:0]))
                            : (k1 >= fw_total);

  logic [bbpt_pkg::ADDR_W-1:0] raddr;
  assign raddr = (state_r == S_HDR) ? {13'b0, hdr_cnt_r} : f_addr[bbpt_pkg::ADDR_W-1:0];

  bbpt_store u_store (
    .clk       (clk),
    .we        (app_wr),
    .waddr     (app_cnt[bbpt_pkg::ADDR_W-1:0]),
    .wdata     (in_data.data_byte),
    .raddr     (raddr),
    .rd_data_r (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= 1'b0;
      min_total_r <= 19'd1024;
      scan_win_r  <= 19'd4096;
      min_guess_r <= 19'd65536;
      min_blk_r   <= 16'd64;
      load_cnt_r  <= '0;
      phase_r     <= PH_LOAD;
      recent_r    <= '0;
      mark8_r     <= 1'b0;
      mark16_r    <= 1'b0;
      hdr_type_r  <= '0;
      hdr_blk_r   <= '0;
      hdr_len_r   <= '0;
      mode16_r    <= 1'b0;
      blk_total_r <= '0;
      emit_idx_r  <= '0;
      plane_idx_r <= '0;
      blk_idx_r   <= '0;
      state_r     <= S_IDLE;
      hdr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_addr)
          bbpt_pkg::CFG_DIRECTION: dir_r       <= cfg_wdata[0];
          bbpt_pkg::CFG_MIN_TOTAL: min_total_r <= cfg_wdata;
          bbpt_pkg::CFG_SCAN_WIN:  scan_win_r  <= cfg_wdata;
          bbpt_pkg::CFG_MIN_GUESS: min_guess_r <= cfg_wdata;
          bbpt_pkg::CFG_MIN_BLK:   min_blk_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_data.cmd)
              bbpt_pkg::CMD_APPEND: begin
                phase_r  <= PH_LOAD;
                mark8_r  <= app_mark8;
                mark16_r <= app_mark16;
                if (app_full) begin
                  load_cnt_r  <= app_cnt;
                  recent_r    <= app_recent;
                  out_valid_r <= 1'b1;
                  out_data_r  <= mk_out(bbpt_pkg::ST_OVERFLOW, 8'd0, 1'b0,
                                        bbpt_pkg::KIND_NONE, 19'd0);
                end else begin
                  load_cnt_r <= app_cnt + 19'd1;
                  recent_r   <= app_word[23:0];
                end
              end
              bbpt_pkg::CMD_FINISH: begin
                if (phase_r == PH_LOAD) begin
                  emit_idx_r  <= '0;
                  plane_idx_r <= '0;
                  blk_idx_r   <= '0;
                  phase_r     <= PH_DONE;
                  if (!dir_r) begin
                    out_valid_r <= 1'b1;
                    if (fw_short) begin
                      out_data_r <= mk_out(bbpt_pkg::ST_SHORT, 8'd0, 1'b0,
                                           bbpt_pkg::KIND_NONE, 19'd0);
                    end else if (!fw_fmt_ok) begin
                      out_data_r <= mk_out(bbpt_pkg::ST_NOFMT, 8'd0, 1'b0,
                                           bbpt_pkg::KIND_NONE, 19'd0);
                    end else begin
                      mode16_r    <= fw_m16;
                      blk_total_r <= fw_blocks;
                      if (fw_few) begin
                        out_data_r <= mk_out(bbpt_pkg::ST_SHORT, 8'd0, 1'b0,
                                             bbpt_pkg::KIND_NONE, 19'd0);
                      end else begin
                        hdr_type_r <= fw_m16 ? 32'd5 : 32'd1;
                        hdr_blk_r  <= {45'b0, fw_blocks};
                        hdr_len_r  <= {45'b0, load_cnt_r};
                        phase_r    <= PH_EMIT;
                        out_data_r <= mk_out(bbpt_pkg::ST_ACCEPT, 8'd0, 1'b0,
                                             fw_m16 ? bbpt_pkg::KIND_16 : bbpt_pkg::KIND_8,
                                             fw_total[18:0]);
                      end
                    end
                  end else if (load_cnt_r < 19'(bbpt_pkg::HDR_LEN)) begin
                    out_valid_r <= 1'b1;
                    out_data_r  <= mk_out(bbpt_pkg::ST_BADHDR, 8'd0, 1'b0,
                                          bbpt_pkg::KIND_NONE, 19'd0);
                  end else begin
                    hdr_cnt_r <= '0;
                    state_r   <= S_HDR;
                  end
                end
              end
              bbpt_pkg::CMD_FETCH: begin
                if (phase_r != PH_EMIT) begin
                  out_valid_r <= 1'b1;
                  out_data_r  <= mk_out(bbpt_pkg::ST_EMPTY, 8'd0, 1'b0,
                                        bbpt_pkg::KIND_NONE, 19'd0);
                end else begin
                  f_hdr_r      <= f_from_hdr;
                  f_hdr_byte_r <= hdr_byte;
                  f_oor_r      <= f_oor;
                  f_last_r     <= f_last;
                  emit_idx_r   <= k1[18:0];
                  if (!f_from_hdr) begin
                    blk_idx_r   <= blk_nxt;
                    plane_idx_r <= plane_nxt;
                  end
                  if (f_last) begin
                    phase_r <= PH_DONE;
                  end
                  state_r <= S_FETCH;
                end
              end
              default: ;
            endcase
          end
        end
        S_HDR: begin
          // The byte read at count c arrives in the next cycle, at count c+1.
          hdr_cnt_r <= hdr_cnt_r + 5'd1;
          if (hdr_cnt_r != 5'd0) begin
            hdr_buf_r <= {rd_data, hdr_buf_r[191:8]};
          end
          if (hdr_cnt_r == HDR_LAST) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          out_data_r  <= mk_out(bbpt_pkg::ST_BADHDR, 8'd0, 1'b0, bbpt_pkg::KIND_NONE, 19'd0);
          if (rv_magic_ok) begin
            hdr_type_r <= rv_type;
            hdr_blk_r  <= rv_blk;
            hdr_len_r  <= rv_len;
            if (rv_t1 || rv_t5) begin
              mode16_r <= rv_t5;
              if (!rv_len_bad && !rv_blk_bad) begin
                blk_total_r <= rv_blk[18:0];
                if (rv_len != '0) begin
                  phase_r <= PH_EMIT;
                end
                out_data_r <= mk_out(bbpt_pkg::ST_ACCEPT, 8'd0, 1'b0,
                                     rv_t5 ? bbpt_pkg::KIND_16 : bbpt_pkg::KIND_8,
                                     rv_len[18:0]);
              end
            end
          end
        end
        S_FETCH: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          out_data_r  <= mk_out(bbpt_pkg::ST_BYTE,
                                f_hdr_r ? f_hdr_byte_r : (f_oor_r ? 8'd0 : rd_data),
                                f_last_r,
                                mode16_r ? bbpt_pkg::KIND_16 : bbpt_pkg::KIND_8, 19'd0);
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/bbpt_checker.sv =====
module bbpt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input bbpt_pkg::out_item_t out_data
);

  // Only a byte result carries a byte or the end-of-run flag.
  a_nonbyte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != bbpt_pkg::ST_BYTE) |->
      (out_data.out_byte == 8'd0) && !out_data.out_last)
    else $error("non-byte result carries byte data");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != bbpt_pkg::ST_BYTE) &&
    (out_data.status != bbpt_pkg::ST_ACCEPT) |->
      (out_data.block_kind == bbpt_pkg::KIND_NONE) && (out_data.out_length == 19'd0))
    else $error("rejection carries kind or length");

  a_byte_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == bbpt_pkg::ST_BYTE) |->
      (out_data.block_kind != bbpt_pkg::KIND_NONE) && (out_data.out_length == 19'd0))
    else $error("byte result without block kind");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy) || $past(busy))
    else $error("result without an item in progress");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("activity straight after reset");

endmodule

bind block_byte_plane_transposer bbpt_checker u_bbpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== bench/tb_block_byte_plane_transposer.sv =====
module tb_block_byte_plane_transposer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic [1:0] {MODEL_LOAD, MODEL_EMIT, MODEL_DONE} model_phase_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  bbpt_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  bbpt_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_addr = '0;
  logic [18:0]         cfg_wdata = '0;

  block_byte_plane_transposer dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Register shadows and predicted block state.
  logic        dir_r;
  int unsigned min_total_r, scan_r, min_guess_r, min_blk_r;
  logic [7:0]  store_img [0:bbpt_pkg::MAX_BYTES-1];
  int unsigned fill_count, block_count, emit_pos, plane_pos, block_pos, src_addr;
  model_phase_t phase_r;
  logic [23:0] recent_r;
  logic        seen_dxt1, seen_dxt5, wide_blocks;
  logic [31:0] hdr_type;
  logic [63:0] hdr_blocks, hdr_len;

  bbpt_pkg::in_item_t  pending_items[$];
  bbpt_pkg::out_item_t expected_results[$];
  int        idle_pct = 34;
  int        mismatches = 0, failures = 0, results_checked = 0;
  int        items_accepted = 0, random_items = 0, cycles = 0;

  function automatic bbpt_pkg::out_item_t make_result(logic [2:0] st, logic [7:0] b, logic l,
                                                      logic [1:0] k, logic [63:0] len);
    bbpt_pkg::out_item_t r;
    r.status = st; r.out_byte = b; r.out_last = l; r.block_kind = k;
    r.out_length = len[18:0];
    return r;
  endfunction

  function automatic logic [63:0] read_le(int unsigned at, int unsigned n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v |= 64'(store_img[at + i]) << (8 * i);
    return v;
  endfunction

  function automatic bbpt_pkg::out_item_t decide_finish();
    int unsigned bs;
    logic [63:0] total, payload;
    emit_pos = 0; plane_pos = 0; block_pos = 0; src_addr = 0;
    phase_r = MODEL_DONE;
    if (dir_r == 1'b0) begin
      if (fill_count < min_total_r)
        return make_result(bbpt_pkg::ST_SHORT, 0, 0, bbpt_pkg::KIND_NONE, 0);
      if (seen_dxt1) wide_blocks = 1'b0;
      else if (seen_dxt5) wide_blocks = 1'b1;
      else if (fill_count % 16 == 0 && fill_count >= min_guess_r) wide_blocks = 1'b1;
      else if (fill_count % 8 == 0 && fill_count >= min_guess_r) wide_blocks = 1'b0;
      else return make_result(bbpt_pkg::ST_NOFMT, 0, 0, bbpt_pkg::KIND_NONE, 0);
      bs = wide_blocks ? 16 : 8;
      block_count = fill_count / bs;
      if (block_count < min_blk_r)
        return make_result(bbpt_pkg::ST_SHORT, 0, 0, bbpt_pkg::KIND_NONE, 0);
      hdr_type = wide_blocks ? 32'd5 : 32'd1;
      hdr_blocks = 64'(block_count);
      hdr_len = 64'(fill_count);
      total = 64'(fill_count) + 64'(bbpt_pkg::HDR_LEN);
    end else begin
      if (fill_count < bbpt_pkg::HDR_LEN || read_le(0, 4) != 64'(bbpt_pkg::MAGIC_WORD))
        return make_result(bbpt_pkg::ST_BADHDR, 0, 0, bbpt_pkg::KIND_NONE, 0);
      hdr_type = 32'(read_le(4, 4));
      hdr_blocks = read_le(8, 8);
      hdr_len = read_le(16, 8);
      if (hdr_type == 32'd1) wide_blocks = 1'b0;
      else if (hdr_type == 32'd5) wide_blocks = 1'b1;
      else return make_result(bbpt_pkg::ST_BADHDR, 0, 0, bbpt_pkg::KIND_NONE, 0);
      bs = wide_blocks ? 16 : 8;
      payload = 64'(fill_count - bbpt_pkg::HDR_LEN);
      if (hdr_len > payload || hdr_blocks > hdr_len / bs)
        return make_result(bbpt_pkg::ST_BADHDR, 0, 0, bbpt_pkg::KIND_NONE, 0);
      block_count = hdr_blocks[31:0];
      total = hdr_len;
    end
    if (total > 0) phase_r = MODEL_EMIT;
    return make_result(bbpt_pkg::ST_ACCEPT, 0, 0,
                       wide_blocks ? bbpt_pkg::KIND_16 : bbpt_pkg::KIND_8, total);
  endfunction

  function automatic bbpt_pkg::out_item_t next_output_byte();
    int unsigned bs, k;
    logic [63:0] planes, total;
    logic [7:0] b;
    logic l;
    bs = wide_blocks ? 16 : 8;
    planes = 64'(block_count) * bs;
    total = (dir_r == 1'b0) ? 64'(fill_count) + 64'(bbpt_pkg::HDR_LEN) : hdr_len;
    k = emit_pos;
    if (phase_r != MODEL_EMIT)
      return make_result(bbpt_pkg::ST_EMPTY, 0, 0, bbpt_pkg::KIND_NONE, 0);
    if (dir_r == 1'b0) begin
      if (k < bbpt_pkg::HDR_LEN) begin
        if (k < 4) b = 8'(bbpt_pkg::MAGIC_WORD >> (8 * k));
        else if (k < 8) b = 8'(hdr_type >> (8 * (k - 4)));
        else if (k < 16) b = 8'(hdr_blocks >> (8 * (k - 8)));
        else b = 8'(hdr_len >> (8 * (k - 16)));
      end else begin
        if (64'(k - bbpt_pkg::HDR_LEN) < planes) begin
          src_addr = block_pos * bs + plane_pos;
          block_pos++;
          if (block_pos >= block_count) begin
            block_pos = 0;
            plane_pos = (plane_pos + 1) & 15;
          end
        end else begin
          src_addr = k - bbpt_pkg::HDR_LEN;
        end
        b = store_img[src_addr];
      end
    end else begin
      if (64'(k) < planes) begin
        src_addr = bbpt_pkg::HDR_LEN + plane_pos * block_count + block_pos;
        plane_pos++;
        if (plane_pos >= bs) begin
          plane_pos = 0;
          block_pos++;
        end
      end else begin
        src_addr = bbpt_pkg::HDR_LEN + k;
      end
      b = store_img[src_addr];
    end
    emit_pos = k + 1;
    l = 64'(emit_pos) >= total;
    if (l) phase_r = MODEL_DONE;
    return make_result(bbpt_pkg::ST_BYTE, b, l,
                       wide_blocks ? bbpt_pkg::KIND_16 : bbpt_pkg::KIND_8, 0);
  endfunction

  // Returns 1 when the item produces a result.
  function automatic bit predict_transposer(bbpt_pkg::in_item_t it,
                                            output bbpt_pkg::out_item_t r);
    logic [31:0] w;
    r = '0;
    case (it.cmd)
      bbpt_pkg::CMD_APPEND: begin
        if (phase_r != MODEL_LOAD) begin
          fill_count = 0; phase_r = MODEL_LOAD; recent_r = '0;
          seen_dxt1 = 1'b0; seen_dxt5 = 1'b0;
        end
        if (fill_count >= bbpt_pkg::MAX_BYTES) begin
          r = make_result(bbpt_pkg::ST_OVERFLOW, 0, 0, bbpt_pkg::KIND_NONE, 0);
          return 1'b1;
        end
        w = {recent_r, it.data_byte};
        if (fill_count >= 3 && fill_count < scan_r) begin
          if (w == bbpt_pkg::MARK_DXT1) seen_dxt1 = 1'b1;
          if (w == bbpt_pkg::MARK_DXT5) seen_dxt5 = 1'b1;
        end
        recent_r = w[23:0];
        store_img[fill_count] = it.data_byte;
        fill_count++;
        return 1'b0;
      end
      bbpt_pkg::CMD_FINISH: begin
        if (phase_r != MODEL_LOAD) return 1'b0;
        r = decide_finish();
        return 1'b1;
      end
      bbpt_pkg::CMD_FETCH: begin
        r = next_output_byte();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Driver: a new item is offered once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        in_data <= pending_items.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks results and predicts each accepted item.
  always @(posedge clk) begin
    bbpt_pkg::out_item_t e, r;
    if (rst_n) begin
      if (out_valid) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          failures++;
          if (mismatches < 10) $display("unexpected result %p", out_data);
          mismatches++;
        end else begin
          e = expected_results.pop_front();
          if (out_data.status !== e.status || out_data.out_byte !== e.out_byte ||
              out_data.out_last !== e.out_last || out_data.block_kind !== e.block_kind ||
              out_data.out_length !== e.out_length) begin
            failures++;
            if (mismatches < 10)
              $display("mismatch: expected %p, got %p", e, out_data);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        items_accepted++;
        if (predict_transposer(in_data, r)) expected_results.push_back(r);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_block_byte_plane_transposer failed");
      $finish;
    end
  end

  task automatic push_item(logic [1:0] c, logic [7:0] d);
    bbpt_pkg::in_item_t it;
    it.cmd = c; it.data_byte = d;
    pending_items.push_back(it);
    random_items++;
  endtask

  task automatic push_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) push_item(bbpt_pkg::CMD_APPEND, v[8*i +: 8]);
  endtask

  task automatic push_fetches(int n);
    for (int i = 0; i < n; i++) push_item(bbpt_pkg::CMD_FETCH, 8'($urandom));
  endtask

  // Waits until every item is taken and answered, then lets the block go quiet.
  task automatic settle();
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic d, int unsigned mt, int unsigned sw, int unsigned mg,
                            int unsigned mb);
    logic [18:0] vals [5];
    vals = '{19'(d), 19'(mt), 19'(sw), 19'(mg), 19'(mb)};
    for (int i = bbpt_pkg::CFG_DIRECTION; i <= bbpt_pkg::CFG_MIN_BLK; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= 3'(i);
      cfg_wdata <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    dir_r = d; min_total_r = mt; scan_r = sw; min_guess_r = mg; min_blk_r = mb & 16'hFFFF;
  endtask

  task automatic forward_run();
    int unsigned len, pos;
    logic [7:0] bytes [$];
    case ($urandom_range(0, 3))
      0: len = $urandom_range(0, 40);
      1: len = 8 * $urandom_range(1, 16);
      2: len = 16 * $urandom_range(1, 8);
      default: len = $urandom_range(40, 150);
    endcase
    for (int i = 0; i < len; i++) bytes.push_back(8'($urandom));
    if (len >= 4 && $urandom_range(0, 2) != 0) begin
      pos = $urandom_range(0, len - 4);
      bytes[pos] = "D"; bytes[pos+1] = "X"; bytes[pos+2] = "T";
      bytes[pos+3] = $urandom_range(0, 1) ? "1" : "5";
    end
    foreach (bytes[i]) begin
      if ($urandom_range(0, 99) < 2) push_item(bbpt_pkg::CMD_SPARE, 8'($urandom));
      push_item(bbpt_pkg::CMD_APPEND, bytes[i]);
    end
    push_item(bbpt_pkg::CMD_FINISH, 8'($urandom));
    if ($urandom_range(0, 9) == 0) push_item(bbpt_pkg::CMD_FINISH, 8'($urandom));
    // Now and then a read-out is abandoned part way.
    push_fetches($urandom_range(0, 9) == 0 ? $urandom_range(0, len) : len + 24 + 1);
  endtask

  task automatic reverse_run();
    int unsigned bs, olen, pay;
    logic [31:0] magic, kind;
    logic [63:0] nblk, hlen;
    bs = $urandom_range(0, 1) ? 16 : 8;
    kind = (bs == 16) ? 32'd5 : 32'd1;
    if ($urandom_range(0, 9) == 0) kind = $urandom;
    olen = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 120);
    nblk = 64'($urandom_range(0, olen / bs));
    pay = olen + $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) nblk = nblk + 64'(1 + $urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) pay = $urandom_range(0, olen);
    hlen = 64'(olen);
    if ($urandom_range(0, 19) == 0) hlen[8*$urandom_range(3, 7) +: 8] = 8'($urandom);
    if ($urandom_range(0, 19) == 0) nblk[8*$urandom_range(1, 7) +: 8] = 8'($urandom);
    magic = bbpt_pkg::MAGIC_WORD;
    if ($urandom_range(0, 14) == 0) magic[8*$urandom_range(0, 3) +: 8] = 8'($urandom);
    if ($urandom_range(0, 14) == 0) begin
      push_le({32'($urandom), magic}, $urandom_range(0, 23) % 8);
    end else begin
      push_le(64'(magic), 4);
      push_le(64'(kind), 4);
      push_le(nblk, 8);
      push_le(hlen, 8);
      for (int i = 0; i < pay; i++) push_item(bbpt_pkg::CMD_APPEND, 8'($urandom));
    end
    push_item(bbpt_pkg::CMD_FINISH, 8'($urandom));
    push_fetches($urandom_range(0, 9) == 0 ? $urandom_range(0, olen) : olen + 1);
  endtask

  initial begin
    int unsigned setting [8][5];
    setting = '{'{0, 16, 64, 32, 2}, '{0, 0, 4, 0, 0}, '{1, 0, 4, 0, 0},
                '{0, 262144, 262144, 262144, 32768}, '{0, 8, 262144, 24, 1},
                '{1, 262144, 262144, 262144, 32768}, '{0, 32, 20, 262144, 4},
                '{1, 64, 4096, 65536, 64}};
    dir_r = 1'b0; min_total_r = 1024; scan_r = 4096; min_guess_r = 65536; min_blk_r = 64;
    fill_count = 0; phase_r = MODEL_LOAD; recent_r = '0; seen_dxt1 = 0; seen_dxt5 = 0;
    wide_blocks = 0; hdr_type = 0; hdr_blocks = 0; hdr_len = 0;
    block_count = 0; emit_pos = 0; plane_pos = 0; block_pos = 0; src_addr = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Fetch before any load, an empty finish, the unused command, a repeated finish.
    push_fetches(1);
    push_item(bbpt_pkg::CMD_SPARE, 8'hFF);
    push_item(bbpt_pkg::CMD_FINISH, 8'h00);
    push_item(bbpt_pkg::CMD_FINISH, 8'hFF);
    push_fetches(1);
    settle();

    random_items = 0;
    for (int s = 0; s < 8; s++) begin
      write_regs(1'(setting[s][0]), setting[s][1], setting[s][2], setting[s][3],
                 setting[s][4]);
      idle_pct = (s == 1) ? 0 : 34;
      while (random_items < (s + 1) * RANDOM_ITEMS / 8) begin
        if (dir_r) reverse_run();
        else forward_run();
      end
      settle();
    end

    $display("%0d items accepted, %0d results checked over 8 register settings", items_accepted,
             results_checked);
    $display("forward and reverse runs, malformed headers and stray commands");
    if (failures == 0 && expected_results.size() == 0) begin
      $display("tb_block_byte_plane_transposer passed");
    end else begin
      $display("%0d failures, %0d results never arrived", failures, expected_results.size());
      $display("tb_block_byte_plane_transposer failed");
    end
    $finish;
  end

endmodule

// ===== block_byte_plane_transposer.f =====
rtl/bbpt_pkg.sv
rtl/bbpt_store.sv
rtl/block_byte_plane_transposer.sv
rtl/bbpt_checker.sv
bench/tb_block_byte_plane_transposer.sv
